/* rtl/bmh_pkg.sv */
// Package for the binary max-heap priority queue.
// Holds the key type, operation codes and the command/status structs
// shared by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package bmh_pkg;

    // Key and output widths fixed by the interface.
    localparam int KEY_W       = 32;
    localparam int CNT_OUT_W   = 7;
    localparam int CAPACITY_DEF = 64;

    typedef logic signed [KEY_W-1:0] t_key;

    // Operation codes carried on the request channel.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_ins;   // Latch key, grow the heap, start at the new tail.
        logic start_del;   // Shrink the heap, read the old tail entry.
        logic refuse;      // Mark the operation as refused.
        logic load_last;   // Take the old tail entry as the moving key.
        logic up_read;     // Read the parent of the current slot.
        logic up_move;     // Move the parent down, climb one level.
        logic dn_read;     // Read both children of the current slot.
        logic dn_move;     // Move the chosen child up, descend one level.
        logic write_key;   // Drop the moving key into the current slot.
        logic load_rsp;    // Load the response register.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // Heap holds CAPACITY entries.
        logic empty;       // Heap holds no entries.
        logic pos_gt1;     // Current slot is below the root.
        logic left_le_n;   // Current slot has a left child.
        logic up_greater;  // Moving key beats its parent.
        logic dn_greater;  // Larger child beats the moving key.
    } t_status;

endpackage

`default_nettype wire

/* rtl/bmh_stream_if.sv */
// Valid/ready channel interfaces for requests and responses of the heap.
// Depends on bmh_pkg for the key type.
`default_nettype none

interface bmh_req_if;
    logic          valid;
    logic          ready;
    logic          operation;
    bmh_pkg::t_key key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface bmh_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    bmh_pkg::t_key                 top_key;
    logic                          is_empty;
    logic [bmh_pkg::CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output accepted, output top_key, output is_empty,
                    output entry_count, input ready);
    modport sink   (input valid, input accepted, input top_key, input is_empty,
                    input entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/binary_max_heap_priority_queue_top.sv */
// Binary max-heap priority queue of signed 32-bit keys, CAPACITY entries
// deep. Each request inserts a key (operation 0) or removes the maximum
// (operation 1) and yields one response with the accepted flag, the largest
// key left (0 when empty), an empty flag and the entry count. Requests are
// served one at a time: an insert climbs L levels (it stops early at the
// root or once its parent is not smaller), a delete descends L levels (it
// stops early at a leaf or once no child is larger), and a refused request
// does no walk; L is at most log2(CAPACITY). Each level costs one
// registered read of the entry memory and one compare-and-write step. A
// finished response sits in an output register, so the next request is
// taken while it waits. The entry memory needs no clearing after reset.
// Depends on bmh_pkg, bmh_stream_if, bmh_ctrl and bmh_datapath.
`default_nettype none

module binary_max_heap_priority_queue_top #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bmh_req_if.sink   i_req,
    bmh_rsp_if.source o_rsp
);

    bmh_pkg::t_cmd    cmd;
    bmh_pkg::t_status status;
    logic             req_ready;
    logic             rsp_valid;

    // Sequencing of each operation.
    bmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.operation),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Entry storage and compare logic.
    bmh_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_key         (i_req.key),
        .o_status      (status),
        .o_accepted    (o_rsp.accepted),
        .o_top_key     (o_rsp.top_key),
        .o_is_empty    (o_rsp.is_empty),
        .o_entry_count (o_rsp.entry_count)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

    // An empty heap always reports a zero top key.
    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.is_empty) |-> (o_rsp.top_key == '0))
        else $error("empty heap reported a nonzero top key");

    // The fill count can never be both full and empty.
    a_full_empty_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.full && status.empty))
        else $error("heap reported full and empty at once");

    // After a request transaction the block is busy in the cycle after it.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one still in progress");

    // A response is loaded only when the register is free or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_rsp |-> (!o_rsp.valid || o_rsp.ready))
        else $error("response register overwritten before transaction");

endmodule

`default_nettype wire

/* rtl/bmh_datapath.sv */
// Datapath of the heap: entry memory with two registered read ports,
// moving key, slot pointer, fill count, root shadow and response register.
// Depends on bmh_pkg for the command and status structs.
`default_nettype none

module bmh_datapath #(
    parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bmh_pkg::t_cmd                 i_cmd,
    input  wire bmh_pkg::t_key                 i_key,
    output bmh_pkg::t_status                   o_status,
    output logic                               o_accepted,
    output bmh_pkg::t_key                      o_top_key,
    output logic                               o_is_empty,
    output logic [bmh_pkg::CNT_OUT_W-1:0]      o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    // Entry memory, slot s lives at address s - 1.
    bmh_pkg::t_key r_heap [CAPACITY];
    bmh_pkg::t_key r_rd_a;
    bmh_pkg::t_key r_rd_b;

    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_pos, n_pos;
    bmh_pkg::t_key r_key, n_key;
    bmh_pkg::t_key r_top;
    logic          r_ok, n_ok;

    bmh_pkg::t_key                r_rsp_top;
    logic                         r_rsp_ok;
    logic                         r_rsp_empty;
    logic [bmh_pkg::CNT_OUT_W-1:0] r_rsp_count;

    logic [SW-1:0] count_ext;
    logic [SW-1:0] left_slot;
    logic [SW-1:0] right_slot;
    logic [SW-1:0] parent_slot;
    logic [SW-1:0] pos_m1;
    logic [SW-1:0] parent_m1;
    logic [SW-1:0] left_m1;
    logic [CW-1:0] count_m1;
    logic          right_le_n;
    logic          pick_right;
    bmh_pkg::t_key pick_val;
    logic [CW+bmh_pkg::CNT_OUT_W-1:0] count_wide;

    logic [AW-1:0] raddr_a, raddr_b, waddr;
    logic          we;
    bmh_pkg::t_key wdata;

    // Slot arithmetic around the current position.
    assign count_ext   = {1'b0, r_count};
    assign left_slot   = {r_pos[SW-2:0], 1'b0};
    assign right_slot  = {r_pos[SW-2:0], 1'b1};
    assign parent_slot = {1'b0, r_pos[SW-1:1]};
    assign pos_m1      = r_pos - SW'(1);
    assign parent_m1   = parent_slot - SW'(1);
    assign left_m1     = left_slot - SW'(1);
    assign count_m1    = r_count - CW'(1);
    assign right_le_n  = right_slot <= count_ext;

    // Larger child; the right one wins a tie.
    assign pick_right = right_le_n && !(r_rd_a > r_rd_b);
    assign pick_val   = pick_right ? r_rd_b : r_rd_a;

    // Status toward the controller.
    assign o_status.full       = r_count == CW'(CAPACITY);
    assign o_status.empty      = r_count == '0;
    assign o_status.pos_gt1    = r_pos > SW'(1);
    assign o_status.left_le_n  = left_slot <= count_ext;
    assign o_status.up_greater = r_key > r_rd_a;
    assign o_status.dn_greater = pick_val > r_key;

    // Read address selection.
    always_comb begin
        raddr_a = '0;
        raddr_b = '0;
        if (i_cmd.start_del) begin
            raddr_a = count_m1[AW-1:0];
        end else if (i_cmd.up_read) begin
            raddr_a = parent_m1[AW-1:0];
        end else if (i_cmd.dn_read) begin
            raddr_a = left_m1[AW-1:0];
            raddr_b = right_le_n ? left_slot[AW-1:0] : left_m1[AW-1:0];
        end
    end

    // Every write lands in the current slot.
    always_comb begin
        waddr = pos_m1[AW-1:0];
        we    = i_cmd.up_move | i_cmd.dn_move | i_cmd.write_key;
        priority if (i_cmd.up_move) begin
            wdata = r_rd_a;
        end else if (i_cmd.dn_move) begin
            wdata = pick_val;
        end else begin
            wdata = r_key;
        end
    end

    // Memory with registered reads.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_heap[waddr] <= wdata;
        end
        r_rd_a <= r_heap[raddr_a];
        r_rd_b <= r_heap[raddr_b];
    end

    // Shadow of the root slot, kept in step with every write to it.
    always_ff @(posedge i_clk) begin
        if (we && (waddr == '0)) begin
            r_top <= wdata;
        end
    end

    // Next values of the working registers.
    always_comb begin
        n_count = r_count;
        n_pos   = r_pos;
        n_key   = r_key;
        n_ok    = r_ok;
        if (i_cmd.start_ins) begin
            n_count = r_count + CW'(1);
            n_pos   = count_ext + SW'(1);
            n_key   = i_key;
            n_ok    = 1'b1;
        end
        if (i_cmd.start_del) begin
            n_count = count_m1;
            n_pos   = SW'(1);
            n_ok    = 1'b1;
        end
        if (i_cmd.refuse) begin
            n_ok = 1'b0;
        end
        if (i_cmd.load_last) begin
            n_key = r_rd_a;
        end
        if (i_cmd.up_move) begin
            n_pos = parent_slot;
        end
        if (i_cmd.dn_move) begin
            n_pos = pick_right ? right_slot : left_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_pos <= n_pos;
        r_key <= n_key;
        r_ok  <= n_ok;
    end

    // Response register: state of the heap after the operation.
    assign count_wide = {{bmh_pkg::CNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_rsp_ok    <= r_ok;
            r_rsp_top   <= o_status.empty ? '0 : r_top;
            r_rsp_empty <= o_status.empty;
            r_rsp_count <= count_wide[bmh_pkg::CNT_OUT_W-1:0];
        end
    end

    assign o_accepted    = r_rsp_ok;
    assign o_top_key     = r_rsp_top;
    assign o_is_empty    = r_rsp_empty;
    assign o_entry_count = r_rsp_count;

endmodule

`default_nettype wire

/* rtl/bmh_ctrl.sv */
// Controller of the heap: state machine that sequences sift-up and
// sift-down through the datapath and owns both handshakes.
// Depends on bmh_pkg for the command and status structs.
`default_nettype none

module bmh_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire logic             i_req_op,
    output logic                  o_req_ready,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    input  wire bmh_pkg::t_status i_status,
    output bmh_pkg::t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAST   = 3'd1;
    localparam logic [2:0] S_UP_RD  = 3'd2;
    localparam logic [2:0] S_UP_CMP = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_rsp_valid, n_rsp_valid;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_op == bmh_pkg::OP_INSERT) begin
                        if (i_status.full) begin
                            o_cmd.refuse = 1'b1;
                            n_state      = S_FIN;
                        end else begin
                            o_cmd.start_ins = 1'b1;
                            n_state         = S_UP_RD;
                        end
                    end else begin
                        if (i_status.empty) begin
                            o_cmd.refuse = 1'b1;
                            n_state      = S_FIN;
                        end else begin
                            o_cmd.start_del = 1'b1;
                            n_state         = S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                o_cmd.load_last = 1'b1;
                n_state         = S_DN_RD;
            end
            S_UP_RD: begin
                if (i_status.pos_gt1) begin
                    o_cmd.up_read = 1'b1;
                    n_state       = S_UP_CMP;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_UP_CMP: begin
                if (i_status.up_greater) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_DN_RD: begin
                if (i_status.left_le_n) begin
                    o_cmd.dn_read = 1'b1;
                    n_state       = S_DN_CMP;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_DN_CMP: begin
                if (i_status.dn_greater) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                // Wait until the response register is free.
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.load_rsp = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Response valid flag: set on load, cleared when the transaction completes.
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        if (o_cmd.load_rsp) begin
            n_rsp_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

/* tb/bmh_heap_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the binary max-heap: watches the request and response channels,
// predicts each response with its own heap copy and compares it field by field.
// Depends on bmh_pkg and the channel interfaces in bmh_stream_if.
module bmh_heap_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmh_req_if        i_req,
    bmh_rsp_if        i_rsp,
    output int        o_mismatch_count,
    output int        o_pending
);

    localparam int HEAP_DEPTH = bmh_pkg::CAPACITY_DEF;

    typedef struct {
        logic                          accepted;
        bmh_pkg::t_key                 top_key;
        logic                          is_empty;
        logic [bmh_pkg::CNT_OUT_W-1:0] entry_count;
    } t_heap_status;

    // Shadow heap, slots 1..HEAP_DEPTH, and its fill level.
    bmh_pkg::t_key heap_keys [1:HEAP_DEPTH];
    int            heap_fill;
    t_heap_status  status_queue [$];

    // Swap two shadow slots.
    function automatic void swap_slots(input int a, input int b);
        bmh_pkg::t_key tmp;
        tmp          = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endfunction

    // Apply one operation to the shadow heap and return the status it leaves.
    function automatic t_heap_status heap_apply(input logic op, input bmh_pkg::t_key key);
        t_heap_status st;
        int           pos;
        int           left;
        int           pick;
        logic         done;
        st.accepted = 1'b0;
        if (op == bmh_pkg::OP_INSERT) begin
            if (heap_fill < HEAP_DEPTH) begin
                heap_fill            = heap_fill + 1;
                heap_keys[heap_fill] = key;
                pos  = heap_fill;
                done = 1'b0;
                // Climb while strictly greater than the parent.
                while (pos > 1 && !done) begin
                    if (heap_keys[pos] > heap_keys[pos / 2]) begin
                        swap_slots(pos, pos / 2);
                        pos = pos / 2;
                    end else begin
                        done = 1'b1;
                    end
                end
                st.accepted = 1'b1;
            end
        end else begin
            if (heap_fill > 0) begin
                heap_keys[1] = heap_keys[heap_fill];
                heap_fill    = heap_fill - 1;
                pos  = 1;
                done = 1'b0;
                // Descend toward the larger child; ties go to the right child.
                while (!done) begin
                    left = 2 * pos;
                    if (left + 1 <= heap_fill) begin
                        pick = (heap_keys[left] > heap_keys[left + 1]) ? left : left + 1;
                    end else if (left <= heap_fill) begin
                        pick = left;
                    end else begin
                        pick = 0;
                    end
                    if (pick != 0 && heap_keys[pick] > heap_keys[pos]) begin
                        swap_slots(pos, pick);
                        pos = pick;
                    end else begin
                        done = 1'b1;
                    end
                end
                st.accepted = 1'b1;
            end
        end
        st.top_key     = (heap_fill > 0) ? heap_keys[1] : '0;
        st.is_empty    = (heap_fill == 0);
        st.entry_count = heap_fill[bmh_pkg::CNT_OUT_W-1:0];
        return st;
    endfunction

    assign o_pending = status_queue.size();

    initial begin
        o_mismatch_count = 0;
        heap_fill        = 0;
    end

    // Check the response transaction first, then record the request transaction.
    always @(posedge i_clk) begin
        t_heap_status want;
        t_heap_status got;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.accepted    = i_rsp.accepted;
                got.top_key     = i_rsp.top_key;
                got.is_empty    = i_rsp.is_empty;
                got.entry_count = i_rsp.entry_count;
                if (status_queue.size() == 0) begin
                    $display("%0t: response with nothing expected: acc=%b top=%0d empty=%b cnt=%0d",
                             $time, got.accepted, got.top_key, got.is_empty, got.entry_count);
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = status_queue.pop_front();
                    if (got.accepted !== want.accepted || got.top_key !== want.top_key ||
                        got.is_empty !== want.is_empty ||
                        got.entry_count !== want.entry_count) begin
                        $display("%0t: expected acc=%b top=%0d empty=%b cnt=%0d", $time,
                                 want.accepted, want.top_key, want.is_empty, want.entry_count);
                        $display("%0t: actual   acc=%b top=%0d empty=%b cnt=%0d", $time,
                                 got.accepted, got.top_key, got.is_empty, got.entry_count);
                        o_mismatch_count <= o_mismatch_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                status_queue.push_back(heap_apply(i_req.operation, i_req.key));
            end
        end
    end

endmodule

/* tb/binary_max_heap_priority_queue_top_tb.sv */
`timescale 1ns / 100ps
// Top of the heap testbench: clock, reset, request stimulus and response stalls,
// and the final verdict. Depends on bmh_pkg, bmh_stream_if, the heap top and bmh_heap_checker.
module binary_max_heap_priority_queue_top_tb;

    localparam int            CYCLE_LIMIT   = 300000;
    localparam int            SEGMENT_ITEMS = 70;
    localparam bmh_pkg::t_key KEY_MAX = 32'sh7fffffff;
    localparam bmh_pkg::t_key KEY_MIN = 32'sh80000000;

    logic          i_clk;
    logic          i_rst_n;
    int            mismatch_count;
    int            pending_count;
    int            cycle_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    bmh_pkg::t_key last_key;

    bmh_req_if req ();
    bmh_rsp_if rsp ();

    binary_max_heap_priority_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    bmh_heap_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req),
        .i_rsp            (rsp),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_count)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit in case the block hangs.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_max_heap_priority_queue_top: mismatch");
            $finish;
        end
    end

    // Response side: stall at the current rate.
    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request transaction and wait for it to be taken. Valid stays
    // high afterwards so back-to-back transactions need no toggle.
    task automatic send_op(input logic op, input bmh_pkg::t_key key);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.key       <= key;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // Keys lean toward extremes, small values and repeats so ties occur often.
    function automatic bmh_pkg::t_key pick_key();
        bmh_pkg::t_key k;
        case ($urandom_range(5))
            0, 1, 2: k = $urandom;
            3:       k = $signed($urandom_range(8)) - 4;
            4: begin
                case ($urandom_range(3))
                    0:       k = KEY_MAX;
                    1:       k = KEY_MIN;
                    2:       k = '0;
                    default: k = -1;
                endcase
            end
            default: k = last_key;
        endcase
        last_key = k;
        return k;
    endfunction

    // A run of mostly inserts or mostly deletes, so the heap goes full and empty.
    task automatic send_segment(input logic main_op, input int items);
        logic op;
        for (int n = 0; n < items; n++) begin
            op = ($urandom_range(99) < 97) ? main_op : ~main_op;
            send_op(op, pick_key());
        end
    endtask

    // Directed opening, then three stall profiles of random traffic.
    initial begin
        req.valid     <= 1'b0;
        req.operation <= bmh_pkg::OP_INSERT;
        req.key       <= '0;
        i_rst_n       <= 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 86;
        last_key      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Delete on an empty heap is refused.
        send_op(bmh_pkg::OP_DELETE, '0);
        // Extremes and equal keys.
        send_op(bmh_pkg::OP_INSERT, '0);
        send_op(bmh_pkg::OP_INSERT, KEY_MAX);
        send_op(bmh_pkg::OP_INSERT, KEY_MIN);
        send_op(bmh_pkg::OP_INSERT, -1);
        send_op(bmh_pkg::OP_INSERT, 1);
        send_op(bmh_pkg::OP_INSERT, KEY_MAX);
        send_op(bmh_pkg::OP_INSERT, KEY_MIN);
        send_op(bmh_pkg::OP_INSERT, 5);
        send_op(bmh_pkg::OP_INSERT, 5);
        send_op(bmh_pkg::OP_INSERT, 5);
        // Drain to empty, with the delete key carrying noise, then refuse again.
        for (int n = 0; n < 11; n++) send_op(bmh_pkg::OP_DELETE, $urandom);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            send_segment(bmh_pkg::OP_INSERT, SEGMENT_ITEMS);
            send_segment(bmh_pkg::OP_DELETE, SEGMENT_ITEMS);
        end
        req.valid <= 1'b0;

        // Drain remaining responses, then allow the block to settle.
        while (pending_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("binary_max_heap_priority_queue_top: match");
        end else begin
            $display("binary_max_heap_priority_queue_top: mismatch");
        end
        $finish;
    end

endmodule
